>>> rtl/fsa_pkg.sv
// ----------------------------------------------------------------------------
// fsa_pkg: shared types and constants of the FIFO slot allocator
// Field widths, result status codes, register indexes and the command and
// status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package fsa_pkg;

    localparam int ID_W         = 13;
    localparam int TIME_W       = 31;
    localparam int SLOT_FIELD_W = 11;
    localparam int STATUS_W     = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 31;
    localparam int S_TDATA_W    = 48;
    localparam int M_TDATA_W    = 16;

    localparam int RESET_NUM_SLOTS = 1024;
    localparam logic [TIME_W-1:0] RESET_TIME_LIMIT = 31'h7FFF_FFFF;

    localparam logic FUNC_ARRIVAL   = 1'b0;
    localparam logic FUNC_DEPARTURE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STS_GRANTED  = 3'd0,
        STS_FULL     = 3'd1,
        STS_RELEASED = 3'd2,
        STS_NOTHING  = 3'd3,
        STS_LATE     = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_SLOTS  = 2'd0,
        CFG_TIME_LIMIT = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic load;   // latch an accepted event and start the table reads
        logic exec;   // resolve the event, write back, load the result
        logic clear;  // one step of the request table clearing pass
    } fsa_cmd_t;

    typedef struct packed {
        logic clear_done;  // clearing pass writes its last entry this cycle
        logic out_stall;   // result register full and not taken
    } fsa_sts_t;

endpackage

>>> rtl/fsa_ram.sv
// ----------------------------------------------------------------------------
// fsa_ram: generic single-clock RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fsa_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/fsa_ctrl.sv
// ----------------------------------------------------------------------------
// fsa_ctrl: allocator controller
// Sequences the clearing pass after reset, event acceptance and the
// resolve/write-back step.
// ----------------------------------------------------------------------------
module fsa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output fsa_pkg::fsa_cmd_t  cmd,
    input  fsa_pkg::fsa_sts_t  sts
);
    import fsa_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } ctl_state_t;

    ctl_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (sts.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!sts.out_stall) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cmd.clear = (state_reg == ST_CLEAR);
    assign cmd.load  = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.exec  = (state_reg == ST_EXEC) && !sts.out_stall;

endmodule

>>> rtl/fsa_datapath.sv
// ----------------------------------------------------------------------------
// fsa_datapath: allocator datapath
// Free queue and request table memories, queue pointers and counters,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module fsa_datapath #(
    parameter int MAX_SLOTS    = 1024,
    parameter int MAX_REQUESTS = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  fsa_pkg::fsa_cmd_t                   cmd,
    output fsa_pkg::fsa_sts_t                   sts,
    input  logic                                in_func,
    input  logic [fsa_pkg::ID_W-1:0]            in_request_id,
    input  logic [fsa_pkg::TIME_W-1:0]          in_event_time,
    input  logic                                cfg_valid,
    input  logic [fsa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fsa_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [fsa_pkg::STATUS_W-1:0]        m_status,
    output logic [fsa_pkg::SLOT_FIELD_W-1:0]    m_slot
);
    import fsa_pkg::*;

    localparam int PTR_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SLOT_W = $clog2(MAX_SLOTS + 1);
    localparam int REQ_AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int RESET_NS = (MAX_SLOTS < RESET_NUM_SLOTS) ? MAX_SLOTS : RESET_NUM_SLOTS;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (32'(p) == MAX_SLOTS - 1) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    // Queue position where the tail stands right after a reload.
    function automatic logic [PTR_W-1:0] tail_base(input logic [SLOT_W-1:0] ns);
        if (32'(ns) >= MAX_SLOTS) begin
            return '0;
        end
        return PTR_W'(ns);
    endfunction

    // Architectural state.
    logic [SLOT_W-1:0] ns_reg, ns_next;
    logic [TIME_W-1:0] tlim_reg, tlim_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [SLOT_W-1:0] cnt_reg, cnt_next;
    // Number of queue writes since the last reload, saturating at the depth.
    logic [SLOT_W-1:0] fill_reg, fill_next;
    logic [REQ_AW-1:0] clr_reg, clr_next;
    logic              mvalid_reg, mvalid_next;

    // Event held between acceptance and resolution.
    logic              func_reg;
    logic              idok_reg;
    logic              late_reg;
    logic [REQ_AW-1:0] k_reg;
    logic              unwr_reg;
    logic [SLOT_W-1:0] head_init_reg;
    status_t           mstatus_reg;
    logic [SLOT_W-1:0] mslot_reg;

    // Acceptance-side logic.
    logic              in_id_ok;
    logic [REQ_AW-1:0] in_k;
    logic [31:0]       hd, tb, gap;
    logic              head_written;

    assign in_id_ok = (in_request_id != '0) && (32'(in_request_id) <= MAX_REQUESTS);
    assign in_k     = REQ_AW'(in_request_id - ID_W'(1));

    // A queue entry not written since the reload still holds its initial
    // value, which is its position plus one.
    always_comb begin
        hd   = 32'(head_reg);
        tb   = 32'(tail_base(ns_reg));
        gap  = (hd >= tb) ? (hd - tb) : (hd + 32'(MAX_SLOTS) - tb);
        head_written = (32'(fill_reg) >= MAX_SLOTS) || (gap < 32'(fill_reg));
    end

    // Memories.
    logic [SLOT_W-1:0] req_rd, q_rd;
    logic              req_wr_en;
    logic [REQ_AW-1:0] req_wr_addr;
    logic [SLOT_W-1:0] req_wr_data;

    logic              x_req_we;
    logic [SLOT_W-1:0] x_req_wdata;
    logic              x_q_we;
    logic              x_take;
    logic              x_give;
    status_t           x_status;
    logic [SLOT_W-1:0] x_slot;
    logic [SLOT_W-1:0] head_val;

    assign req_wr_en   = cmd.clear || (cmd.exec && x_req_we);
    assign req_wr_addr = cmd.clear ? clr_reg : k_reg;
    assign req_wr_data = cmd.clear ? '0 : x_req_wdata;

    fsa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_REQUESTS)
    ) u_req_ram (
        .aclk    (aclk),
        .wr_en   (req_wr_en),
        .wr_addr (req_wr_addr),
        .wr_data (req_wr_data),
        .rd_en   (cmd.load),
        .rd_addr (in_k),
        .rd_data (req_rd)
    );

    fsa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_SLOTS)
    ) u_queue_ram (
        .aclk    (aclk),
        .wr_en   (cmd.exec && x_q_we),
        .wr_addr (tail_reg),
        .wr_data (req_rd),
        .rd_en   (cmd.load),
        .rd_addr (head_reg),
        .rd_data (q_rd)
    );

    assign head_val = unwr_reg ? head_init_reg : q_rd;

    // Resolution of the held event.
    always_comb begin
        x_status    = STS_LATE;
        x_slot      = '0;
        x_req_we    = 1'b0;
        x_req_wdata = '0;
        x_q_we      = 1'b0;
        x_take      = 1'b0;
        x_give      = 1'b0;
        if (late_reg) begin
            x_status = STS_LATE;
        end else if (func_reg == FUNC_ARRIVAL) begin
            if (!idok_reg) begin
                x_status = STS_FULL;
            end else if (cnt_reg == '0) begin
                x_status = STS_FULL;
                x_req_we = 1'b1;
            end else begin
                x_status    = STS_GRANTED;
                x_slot      = head_val;
                x_req_we    = 1'b1;
                x_req_wdata = head_val;
                x_take      = 1'b1;
            end
        end else begin
            if (!idok_reg || (req_rd == '0)) begin
                x_status = STS_NOTHING;
            end else if (32'(cnt_reg) >= MAX_SLOTS) begin
                // The queue is already full: the slot is dropped.
                x_status = STS_NOTHING;
                x_req_we = 1'b1;
            end else begin
                x_status = STS_RELEASED;
                x_slot   = req_rd;
                x_req_we = 1'b1;
                x_q_we   = 1'b1;
                x_give   = 1'b1;
            end
        end
    end

    // Next state of pointers, counters and configuration.
    logic [SLOT_FIELD_W-1:0] cfg_ns_raw;
    logic [SLOT_W-1:0]       cfg_ns;

    assign cfg_ns_raw = cfg_data[SLOT_FIELD_W-1:0];

    always_comb begin
        if (cfg_ns_raw == '0) begin
            cfg_ns = SLOT_W'(1);
        end else if (32'(cfg_ns_raw) > MAX_SLOTS) begin
            cfg_ns = SLOT_W'(MAX_SLOTS);
        end else begin
            cfg_ns = SLOT_W'(cfg_ns_raw);
        end
    end

    always_comb begin
        ns_next   = ns_reg;
        tlim_next = tlim_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        fill_next = fill_reg;
        if (cfg_valid && (cfg_index == CFG_NUM_SLOTS)) begin
            ns_next   = cfg_ns;
            head_next = '0;
            tail_next = tail_base(cfg_ns);
            cnt_next  = cfg_ns;
            fill_next = '0;
        end else if (cmd.exec) begin
            if (x_take) begin
                head_next = ptr_inc(head_reg);
                cnt_next  = cnt_reg - SLOT_W'(1);
            end
            if (x_give) begin
                tail_next = ptr_inc(tail_reg);
                cnt_next  = cnt_reg + SLOT_W'(1);
                if (32'(fill_reg) < MAX_SLOTS) begin
                    fill_next = fill_reg + SLOT_W'(1);
                end
            end
        end
        if (cfg_valid && (cfg_index == CFG_TIME_LIMIT)) begin
            tlim_next = cfg_data[TIME_W-1:0];
        end
    end

    assign clr_next = cmd.clear ? (clr_reg + REQ_AW'(1)) : clr_reg;

    always_comb begin
        if (cmd.exec) begin
            mvalid_next = 1'b1;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end else begin
            mvalid_next = mvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ns_reg     <= SLOT_W'(RESET_NS);
            tlim_reg   <= RESET_TIME_LIMIT;
            head_reg   <= '0;
            tail_reg   <= tail_base(SLOT_W'(RESET_NS));
            cnt_reg    <= SLOT_W'(RESET_NS);
            fill_reg   <= '0;
            clr_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            ns_reg     <= ns_next;
            tlim_reg   <= tlim_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            cnt_reg    <= cnt_next;
            fill_reg   <= fill_next;
            clr_reg    <= clr_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg      <= in_func;
            idok_reg      <= in_id_ok;
            late_reg      <= (in_event_time > tlim_reg);
            k_reg         <= in_k;
            unwr_reg      <= !head_written;
            head_init_reg <= SLOT_W'(head_reg) + SLOT_W'(1);
        end
        if (cmd.exec) begin
            mstatus_reg <= x_status;
            mslot_reg   <= x_slot;
        end
    end

    assign sts.clear_done = cmd.clear && (32'(clr_reg) == MAX_REQUESTS - 1);
    assign sts.out_stall  = mvalid_reg && !m_tready;

    assign m_tvalid = mvalid_reg;
    assign m_status = mstatus_reg;
    assign m_slot   = SLOT_FIELD_W'(mslot_reg);

endmodule

>>> rtl/fifo_slot_allocator_unit.sv
// ----------------------------------------------------------------------------
// fifo_slot_allocator_unit: slot allocator with a FIFO free list
// Grants slots from the head of a circular free queue to arriving requests
// and returns them to the tail when the requests depart.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Handshake          Payload
//   s_       in   s_tvalid/s_tready  tdata: request_id, event_time; tuser: func
//   m_       out  m_tvalid/m_tready  tdata: status, slot
//   cfg_     in   cfg_valid/cfg_ready index 0 num_slots, 1 time_limit
//
// For each event the transfer cycle issues the reads of the request table
// and of the free queue, and the EXEC state then resolves the event, writes
// the memories back as the event needs and loads the result register.
// A result waiting on m_ holds the resolve step until it is taken.
// After reset the request table is cleared one entry per cycle, through all
// MAX_REQUESTS entries (4096 by default); s_tready stays low meanwhile.
// Configuration transfers are taken in every cycle; writing num_slots
// reloads the free queue at once.
//
module fifo_slot_allocator_unit #(
    parameter int MAX_SLOTS    = 1024,
    parameter int MAX_REQUESTS = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Event input.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [12:0] request_id, [43:13] event_time, [47:44] zero
    input  logic [fsa_pkg::S_TDATA_W-1:0]       s_tdata,
    // [0] func
    input  logic [0:0]                          s_tuser,
    // Result output.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [2:0] status, [13:3] slot, [15:14] zero
    output logic [fsa_pkg::M_TDATA_W-1:0]       m_tdata,
    // Configuration writes.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fsa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fsa_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import fsa_pkg::*;

    fsa_cmd_t cmd;
    fsa_sts_t sts;

    logic [STATUS_W-1:0]     m_status;
    logic [SLOT_FIELD_W-1:0] m_slot;

    // The controller owns the event handshake and sequencing.
    fsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // The datapath holds all storage and the result register.
    fsa_datapath #(
        .MAX_SLOTS    (MAX_SLOTS),
        .MAX_REQUESTS (MAX_REQUESTS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .in_func       (s_tuser[0]),
        .in_request_id (s_tdata[ID_W-1:0]),
        .in_event_time (s_tdata[ID_W+TIME_W-1:ID_W]),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .m_status      (m_status),
        .m_slot        (m_slot)
    );

    // Configuration never stalls.
    assign cfg_ready = 1'b1;

    assign m_tdata = {(M_TDATA_W - STATUS_W - SLOT_FIELD_W)'(0), m_slot, m_status};

endmodule

>>> rtl/fsa_checker.sv
// ----------------------------------------------------------------------------
// fsa_checker: port-level assertions for the slot allocator
// Watches the top-level ports only and is bound to the top level.
// ----------------------------------------------------------------------------
module fsa_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [fsa_pkg::S_TDATA_W-1:0]       s_tdata,
    input logic [0:0]                          s_tuser,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [fsa_pkg::M_TDATA_W-1:0]       m_tdata,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [fsa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input logic [fsa_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import fsa_pkg::*;

    // Reset starts the clearing pass and empties the result register.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("ready or result valid right after reset");

    // Events are handled one at a time.
    a_one_event: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("event accepted while another is in work");

    // A fresh result appears only in answer to an earlier event transfer.
    a_result_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a matching event");

    // Only grants and releases carry a slot number.
    a_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] != STS_GRANTED) && (m_tdata[2:0] != STS_RELEASED)
            |-> (m_tdata[13:3] == '0))
        else $error("slot reported for a status without a slot");

    // A stalled result holds.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind fifo_slot_allocator_unit fsa_checker u_fsa_checker (.*);

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the FIFO slot allocator
// Drives arrival and departure events through the s_ stream, predicts every
// result from its own model of the free queue and the request table, and
// checks each m_ transfer field by field. Several slot counts and time limits
// are exercised, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_top;

    import fsa_pkg::*;

    localparam int MAX_SLOT_COUNT = 1024;
    localparam int MAX_REQ        = 4096;
    // Watchdog: cycles without any transfer. The limit lies well above the
    // clearing pass after reset, which clears all MAX_REQ entries.
    localparam int STALL_LIMIT    = 20000;
    localparam int MAX_SHOWN      = 10;
    // A register index that selects nothing; writes to it must be harmless.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd2;
    localparam logic [TIME_W-1:0]    TIME_MAX       = 31'h7FFF_FFFF;

    typedef struct packed {
        logic              func;
        logic [ID_W-1:0]   rid;
        logic [TIME_W-1:0] t;
    } alloc_event_t;

    typedef struct packed {
        status_t                 status;
        logic [SLOT_FIELD_W-1:0] slot;
    } alloc_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Set by the monitor when the event on s_ was taken at the last edge.
    logic                  ev_fire   = 1'b0;
    // While set, neither stream stalls.
    logic                  quiet     = 1'b0;

    alloc_event_t  pending_events[$];
    alloc_result_t expected_results[$];
    logic [ID_W-1:0] held_ids[$];

    int issued_count   = 0;
    int received_count = 0;
    int config_count   = 0;
    int mismatches     = 0;
    int idle_cycles    = 0;
    int status_seen[5];

    // Model of the allocator state.
    logic [SLOT_FIELD_W-1:0] free_q [MAX_SLOT_COUNT];
    logic [SLOT_FIELD_W-1:0] req_slot [MAX_REQ];
    logic [9:0]              q_head;
    logic [9:0]              q_tail;
    logic [SLOT_FIELD_W-1:0] free_cnt;
    logic [SLOT_FIELD_W-1:0] slot_count;
    logic [TIME_W-1:0]       limit_reg;

    fifo_slot_allocator_unit #(
        .MAX_SLOTS    (MAX_SLOT_COUNT),
        .MAX_REQUESTS (MAX_REQ)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Refill the free queue with slots 1..slot_count, head at zero.
    function automatic void reload_free_queue();
        for (int i = 0; i < MAX_SLOT_COUNT; i++) begin
            free_q[i] = (i < slot_count) ? SLOT_FIELD_W'(i + 1) : '0;
        end
        q_head   = '0;
        q_tail   = slot_count[9:0];
        free_cnt = slot_count;
    endfunction

    function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        logic [SLOT_FIELD_W-1:0] n;
        n = data[SLOT_FIELD_W-1:0];
        if (idx == CFG_NUM_SLOTS) begin
            // A count of zero means one slot; anything above the table is capped.
            if (n == 0) begin
                n = SLOT_FIELD_W'(1);
            end else if (n > MAX_SLOT_COUNT) begin
                n = SLOT_FIELD_W'(MAX_SLOT_COUNT);
            end
            slot_count = n;
            reload_free_queue();
        end else if (idx == CFG_TIME_LIMIT) begin
            limit_reg = data[TIME_W-1:0];
        end
    endfunction

    // Resolve one event against the model and return the result it causes.
    function automatic alloc_result_t predict_alloc(input alloc_event_t ev);
        alloc_result_t r;
        logic          id_ok;
        logic [11:0]   k;
        r.status = STS_LATE;
        r.slot   = '0;
        id_ok    = (ev.rid >= 1) && (ev.rid <= MAX_REQ);
        k        = id_ok ? 12'(ev.rid - 1) : '0;
        if (ev.t > limit_reg) begin
            r.status = STS_LATE;
        end else if (ev.func == FUNC_ARRIVAL) begin
            if (!id_ok) begin
                r.status = STS_FULL;
            end else if (free_cnt == 0) begin
                // A rejected arrival also forgets any earlier grant.
                req_slot[k] = '0;
                r.status    = STS_FULL;
            end else begin
                r.slot      = free_q[q_head];
                q_head      = q_head + 1'b1;
                free_cnt    = free_cnt - 1'b1;
                req_slot[k] = r.slot;
                r.status    = STS_GRANTED;
            end
        end else begin
            if (!id_ok || req_slot[k] == 0) begin
                r.status = STS_NOTHING;
            end else if (free_cnt >= MAX_SLOT_COUNT) begin
                // Queue refilled under a held slot: the slot is dropped.
                req_slot[k] = '0;
                r.status    = STS_NOTHING;
            end else begin
                r.slot         = req_slot[k];
                free_q[q_tail] = r.slot;
                q_tail         = q_tail + 1'b1;
                free_cnt       = free_cnt + 1'b1;
                req_slot[k]    = '0;
                r.status       = STS_RELEASED;
            end
        end
        return r;
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_event(input logic func, input logic [ID_W-1:0] rid,
                              input logic [TIME_W-1:0] t);
        alloc_event_t ev;
        ev.func = func;
        ev.rid  = rid;
        ev.t    = t;
        pending_events = {pending_events, ev};
        issued_count++;
    endtask

    // Random events with non-decreasing times. Most are arrivals of ids from
    // a pool and departures of ids that arrived earlier; a few are noise with
    // any id and any kind. Some departed ids stay listed for a second try.
    task automatic queue_random(input int count, input int arr_pct, input int id_pool,
                                input logic [TIME_W-1:0] start_t, input int max_step);
        logic [TIME_W-1:0] t;
        logic [ID_W-1:0]   rid;
        int                roll;
        int                pick;
        t = start_t;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (t < TIME_MAX - max_step) begin
                t = t + TIME_W'($urandom_range(0, max_step));
            end
            if (roll < 5) begin
                push_event(1'($urandom_range(0, 1)), ID_W'($urandom_range(0, 8191)), t);
            end else if (roll < 5 + arr_pct * 95 / 100 || held_ids.size() == 0) begin
                rid = ID_W'($urandom_range(1, id_pool));
                held_ids = {held_ids, rid};
                push_event(FUNC_ARRIVAL, rid, t);
            end else begin
                pick = $urandom_range(0, held_ids.size() - 1);
                rid  = held_ids[pick];
                if ($urandom_range(0, 9) != 0) begin
                    held_ids.delete(pick);
                end
                push_event(FUNC_DEPARTURE, rid, t);
            end
        end
    endtask

    // Wait until every event has produced its result.
    task automatic settle();
        while (received_count != issued_count) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Driver: new inputs go out on the falling edge. An event is held until
    // its transfer is seen, then the next one follows or the stream idles.
    always @(negedge aclk) begin
        alloc_event_t ev;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet || ($urandom_range(0, 99) >= 38);
            if (!s_tvalid || ev_fire) begin
                if (pending_events.size() != 0 && (quiet || $urandom_range(0, 99) >= 38)) begin
                    ev = pending_events.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= ev.func;
                    s_tdata  <= {4'b0, ev.t, ev.rid};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: samples all three channels on the rising edge. Configuration
    // and events update the model at their transfer; each result transfer is
    // checked against the oldest expectation.
    always @(posedge aclk) begin
        alloc_event_t            ev;
        alloc_result_t           want;
        logic [STATUS_W-1:0]     got_status;
        logic [SLOT_FIELD_W-1:0] got_slot;
        ev_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                apply_config(cfg_index, cfg_data);
                config_count++;
            end
            if (s_tvalid && s_tready) begin
                ev.func = s_tuser[0];
                ev.rid  = s_tdata[ID_W-1:0];
                ev.t    = s_tdata[ID_W+TIME_W-1:ID_W];
                expected_results = {expected_results, predict_alloc(ev)};
            end
            if (m_tvalid && m_tready) begin
                got_status = m_tdata[STATUS_W-1:0];
                got_slot   = m_tdata[STATUS_W+SLOT_FIELD_W-1:STATUS_W];
                received_count++;
                if (expected_results.size() == 0) begin
                    if (mismatches < MAX_SHOWN) begin
                        $display("[%0t] unexpected result: status %0d slot %0d",
                                 $time, got_status, got_slot);
                    end
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    status_seen[int'(want.status)]++;
                    if (got_status !== want.status || got_slot !== want.slot) begin
                        if (mismatches < MAX_SHOWN) begin
                            $display({"[%0t] result %0d: status %0d slot %0d, ",
                                      "expected status %0d slot %0d"},
                                     $time, received_count, got_status, got_slot,
                                     want.status, want.slot);
                        end
                        mismatches++;
                    end
                end
            end
        end
        // Watchdog: any transfer on any channel counts as progress.
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d of %0d results seen",
                     STALL_LIMIT, received_count, issued_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        logic [TIME_W-1:0] base;
        // Model state after reset: all slots free, no request holds one.
        slot_count = SLOT_FIELD_W'(RESET_NUM_SLOTS);
        limit_reg  = RESET_TIME_LIMIT;
        for (int i = 0; i < MAX_REQ; i++) begin
            req_slot[i] = '0;
        end
        for (int i = 0; i < 5; i++) begin
            status_seen[i] = 0;
        end
        reload_free_queue();

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part: three slots and a low time limit, so that the queue
        // runs dry and late events are easy to place.
        cfg_write(CFG_NUM_SLOTS, 31'd3);
        cfg_write(CFG_TIME_LIMIT, 31'd1000);
        push_event(FUNC_ARRIVAL,   13'd1,    31'd0);
        push_event(FUNC_ARRIVAL,   13'd4096, 31'd1);
        push_event(FUNC_ARRIVAL,   13'd0,    31'd1);    // id below range
        push_event(FUNC_ARRIVAL,   13'd8191, 31'd2);    // id above range
        push_event(FUNC_ARRIVAL,   13'd5,    31'd3);
        push_event(FUNC_ARRIVAL,   13'd6,    31'd3);    // no slot left
        push_event(FUNC_DEPARTURE, 13'd6,    31'd4);    // departure of a rejected id
        push_event(FUNC_DEPARTURE, 13'd4096, 31'd4);
        push_event(FUNC_DEPARTURE, 13'd4096, 31'd5);    // second departure
        push_event(FUNC_DEPARTURE, 13'd7,    31'd5);    // id that never arrived
        push_event(FUNC_DEPARTURE, 13'd0,    31'd5);
        push_event(FUNC_DEPARTURE, 13'd8191, 31'd6);
        push_event(FUNC_ARRIVAL,   13'd1,    31'd6);    // repeated arrival overwrites
        push_event(FUNC_ARRIVAL,   13'd9,    31'd1000); // exactly at the limit
        push_event(FUNC_ARRIVAL,   13'd10,   31'd1001); // just past the limit
        push_event(FUNC_DEPARTURE, 13'd1,    TIME_MAX);
        settle();

        // Reload to the full table while slots are still held: releasing one
        // of them finds the queue already full. The count is written above
        // its range with junk in the upper data bits.
        cfg_write(CFG_NUM_SLOTS, {20'($urandom), 11'h7FF});
        cfg_write(CFG_UNUSED_IDX, 31'($urandom));
        cfg_write(CFG_TIME_LIMIT, TIME_MAX);
        push_event(FUNC_DEPARTURE, 13'd5,    31'd0);
        push_event(FUNC_ARRIVAL,   13'd11,   31'd7);
        push_event(FUNC_DEPARTURE, 13'd11,   31'd8);
        push_event(FUNC_DEPARTURE, 13'd1,    TIME_MAX);
        push_event(FUNC_ARRIVAL,   13'd4096, TIME_MAX);
        settle();

        // Slot count written as zero, which means a single slot; the limit
        // cuts off the tail of the run.
        base = TIME_W'($urandom_range(0, 32'h7F00_0000));
        cfg_write(CFG_NUM_SLOTS, 31'd0);
        cfg_write(CFG_TIME_LIMIT, base + 31'd200);
        queue_random(60, 50, 4, base, 8);
        settle();

        // Four slots, no limit, both streams without stalls.
        cfg_write(CFG_NUM_SLOTS, 31'd4);
        cfg_write(CFG_TIME_LIMIT, TIME_MAX);
        quiet = 1'b1;
        queue_random(100, 55, 12, TIME_W'($urandom_range(0, 32'h7F00_0000)), 1000);
        settle();
        quiet = 1'b0;

        // Near-full table: the tail pointer wraps after a few releases.
        base = TIME_W'($urandom_range(0, 32'h7F00_0000));
        cfg_write(CFG_NUM_SLOTS, 31'd1020);
        cfg_write(CFG_TIME_LIMIT, base + 31'd2500);
        queue_random(120, 45, MAX_REQ, base, 50);
        settle();

        // Full table under heavy arrival load: the head pointer wraps and
        // the queue runs empty.
        cfg_write(CFG_NUM_SLOTS, 31'd1024);
        cfg_write(CFG_TIME_LIMIT, TIME_MAX);
        queue_random(1150, 100, MAX_REQ, 31'd0, 3);
        settle();

        // Time limit zero: only events at time zero are served.
        cfg_write(CFG_NUM_SLOTS, 31'd7);
        cfg_write(CFG_TIME_LIMIT, 31'd0);
        queue_random(60, 55, 10, 31'd0, 1);
        settle();

        repeat (20) @(posedge aclk);
        $display("covered %0d events and %0d register writes: %0d granted, %0d full,",
                 issued_count, config_count, status_seen[STS_GRANTED], status_seen[STS_FULL]);
        $display("  %0d released, %0d with nothing to release, %0d late; %0d mismatches",
                 status_seen[STS_RELEASED], status_seen[STS_NOTHING], status_seen[STS_LATE],
                 mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> fifo_slot_allocator_unit.f
rtl/fsa_pkg.sv
rtl/fsa_ram.sv
rtl/fsa_ctrl.sv
rtl/fsa_datapath.sv
rtl/fifo_slot_allocator_unit.sv
rtl/fsa_checker.sv
dv/tb_top.sv
